>>> hw/rtl/cfpp_pkg.sv
// Package for the CRC-32 checked packet deframer: sizes, framing bytes,
// status codes, state types and the byte-wise CRC-32 update.
// No dependencies.
`default_nettype none

package cfpp_pkg;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned BufAddrW = $clog2(BufDepth);
  localparam int unsigned FillW    = BufAddrW + 1;

  localparam logic [7:0]  ChSlash  = 8'h2F;
  localparam logic [7:0]  ChStar   = 8'h2A;
  localparam logic [FillW-1:0] FixedOverhead = FillW'(13);

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_NO_HEADER = 2'd1,
    ST_INVALID   = 2'd2,
    ST_DATA      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_BODY    = 3'd3,
    PH_CHECK   = 3'd4,
    PH_TRAILER = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    C_IDLE = 2'd0,
    C_PROC = 2'd1,
    C_READ = 2'd2,
    C_SEND = 2'd3
  } ctl_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] data_byte;
    logic [6:0] packet_size;
    logic       last;
  } result_t;

  // Reflected CRC-32 over one byte. The shifts are linear, so this folds into
  // a shallow XOR network.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crc32_framed_packet_parser_unit.sv
// CRC-32 checked packet deframer. A byte is captured into rx_q when taken
// and processed in C_PROC, which loads any status for it into the output
// register once that register is free; the input is stalled until then. A full,
// stalled output register holds the byte in processing. A good packet is
// replayed from the frame buffer byte by byte (read, then send), with the
// input stalled meanwhile. Reset clears all control state; the frame buffer
// is not cleared, every replayed byte was written in its packet.
// Depends on cfpp_pkg, cfpp_frame_ram and cfpp_out_reg.
`default_nettype none

module crc32_framed_packet_parser_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      status_o,
  output logic [7:0]      data_byte_o,
  output logic [6:0]      packet_size_o,
  output logic            last_o
);
  import cfpp_pkg::*;

  ctl_e              ctl_q, ctl_d;
  phase_e            phase_q, phase_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  frame_len_q, frame_len_d;
  logic [FillW-1:0]  rd_idx_q, rd_idx_d;
  logic [31:0]       crc_q, crc_d;
  logic [31:0]       rx_crc_q, rx_crc_d;
  logic [7:0]        len_lo_q, len_lo_d;
  logic [7:0]        rx_q;

  logic [FillW-1:0]  fill_inc;
  logic [16:0]       len_sum;
  logic [31:0]       crc_base, crc_next;
  logic [7:0]        crc_in;
  logic              mem_we, mem_re;
  logic [7:0]        mem_rdata;
  logic              out_load, out_free;
  result_t           res_new, res_out;

  assign in_stall_o = (ctl_q != C_IDLE);

  assign fill_inc = fill_q + FillW'(1);
  assign len_sum  = {1'b0, rx_q, len_lo_q} + 17'(FixedOverhead);

  // One CRC update a byte. In the checksum phase the constant trailer bytes
  // are folded in instead, one on each of the first two checksum bytes.
  always_comb begin
    crc_base = crc_q;
    crc_in   = rx_q;
    if (phase_q == PH_HEADER && fill_q == '0) begin
      crc_base = CrcInit;
    end
    if (phase_q == PH_CHECK) begin
      crc_in = (fill_q + FillW'(6) == frame_len_q) ? ChStar : ChSlash;
    end
  end

  assign crc_next = crc_byte(crc_base, crc_in);

  cfpp_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (fill_q[BufAddrW-1:0]),
    .wdata_i (rx_q),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[BufAddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  cfpp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .res_i   (res_new),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res_out)
  );

  always_comb begin
    ctl_d       = ctl_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    frame_len_d = frame_len_q;
    rd_idx_d    = rd_idx_q;
    crc_d       = crc_q;
    rx_crc_d    = rx_crc_q;
    len_lo_d    = len_lo_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_load    = 1'b0;
    res_new     = '{status: ST_ACCEPTED, data_byte: 8'd0, packet_size: 7'd0, last: 1'b1};

    unique case (ctl_q)
      C_IDLE: begin
        if (in_valid_i) begin
          ctl_d = C_PROC;
        end
      end
      C_PROC: begin
        if (out_free) begin
          ctl_d    = C_IDLE;
          out_load = 1'b1;
          unique case (phase_q)
            PH_HEADER: begin
              priority if (fill_q == '0 && rx_q == ChSlash) begin
                mem_we = 1'b1;
                fill_d = fill_inc;
                crc_d  = crc_next;
              end else if (fill_q == FillW'(1) && rx_q == ChStar) begin
                mem_we  = 1'b1;
                fill_d  = fill_inc;
                crc_d   = crc_next;
                phase_d = PH_LENGTH;
              end else begin
                fill_d         = '0;
                res_new.status = ST_NO_HEADER;
              end
            end
            PH_LENGTH: begin
              mem_we = 1'b1;
              fill_d = fill_inc;
              crc_d  = crc_next;
              if (fill_q == FillW'(2)) begin
                len_lo_d = rx_q;
              end
              if (fill_inc == FillW'(4)) begin
                if (len_sum > 17'(BufDepth)) begin
                  phase_d        = PH_HEADER;
                  fill_d         = '0;
                  crc_d          = CrcInit;
                  res_new.status = ST_INVALID;
                end else begin
                  frame_len_d = len_sum[FillW-1:0];
                  phase_d     = PH_TYPE;
                end
              end
            end
            PH_TYPE: begin
              mem_we = 1'b1;
              fill_d = fill_inc;
              crc_d  = crc_next;
              if (fill_inc == FillW'(7)) begin
                phase_d = (frame_len_q <= FixedOverhead) ? PH_CHECK : PH_BODY;
              end
            end
            PH_BODY: begin
              mem_we = !fill_q[FillW-1];
              fill_d = fill_inc;
              crc_d  = crc_next;
              if (fill_inc + FillW'(6) == frame_len_q) begin
                phase_d = PH_CHECK;
              end
            end
            PH_CHECK: begin
              mem_we   = !fill_q[FillW-1];
              fill_d   = fill_inc;
              rx_crc_d = {rx_q, rx_crc_q[31:8]};
              if (fill_q + FillW'(6) == frame_len_q || fill_q + FillW'(5) == frame_len_q) begin
                crc_d = crc_next;
              end
              if (fill_inc + FillW'(2) == frame_len_q) begin
                if ((crc_q ^ CrcInit) != {rx_q, rx_crc_q[31:8]}) begin
                  phase_d        = PH_HEADER;
                  fill_d         = '0;
                  crc_d          = CrcInit;
                  res_new.status = ST_INVALID;
                end else begin
                  phase_d = PH_TRAILER;
                end
              end
            end
            PH_TRAILER: begin
              mem_we = !fill_q[FillW-1];
              fill_d = fill_inc;
              priority if (fill_inc + FillW'(1) == frame_len_q && rx_q == ChStar) begin
                res_new.status = ST_ACCEPTED;
              end else if (fill_inc == frame_len_q && rx_q == ChSlash) begin
                // Good packet: replay it from the buffer, no status now.
                out_load = 1'b0;
                phase_d  = PH_HEADER;
                fill_d   = '0;
                crc_d    = CrcInit;
                rd_idx_d = '0;
                ctl_d    = C_READ;
              end else begin
                phase_d        = PH_HEADER;
                fill_d         = '0;
                crc_d          = CrcInit;
                res_new.status = ST_INVALID;
              end
            end
            default: begin
              phase_d        = PH_HEADER;
              fill_d         = '0;
              crc_d          = CrcInit;
              res_new.status = ST_INVALID;
            end
          endcase
        end
      end
      C_READ: begin
        mem_re = 1'b1;
        ctl_d  = C_SEND;
      end
      C_SEND: begin
        if (out_free) begin
          out_load            = 1'b1;
          res_new.status      = ST_DATA;
          res_new.data_byte   = mem_rdata;
          res_new.packet_size = 7'(frame_len_q);
          res_new.last        = (rd_idx_q + FillW'(1) == frame_len_q);
          rd_idx_d            = rd_idx_q + FillW'(1);
          ctl_d               = res_new.last ? C_IDLE : C_READ;
        end
      end
      default: begin
        ctl_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q       <= C_IDLE;
      phase_q     <= PH_HEADER;
      fill_q      <= '0;
      frame_len_q <= '0;
      rd_idx_q    <= '0;
      crc_q       <= CrcInit;
    end else begin
      ctl_q       <= ctl_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      frame_len_q <= frame_len_d;
      rd_idx_q    <= rd_idx_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_crc_q <= rx_crc_d;
    len_lo_q <= len_lo_d;
    if (in_valid_i && !in_stall_o) begin
      rx_q <= rx_byte_i;
    end
  end

  assign status_o      = res_out.status;
  assign data_byte_o   = res_out.data_byte;
  assign packet_size_o = res_out.packet_size;
  assign last_o        = res_out.last;

`ifndef SYNTHESIS
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DATA |-> last_o)
    else $error("status transaction without last marker");

  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DATA |->
      packet_size_o >= 7'(FixedOverhead) && packet_size_o <= 7'(BufDepth))
    else $error("delivered packet size out of range");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(BufDepth))
    else $error("fill index beyond buffer depth");

  a_replay_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q == C_READ |=> ctl_q == C_SEND && phase_q == PH_HEADER)
    else $error("buffer read not followed by send");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/cfpp_frame_ram.sv
// Frame buffer: single write port, single registered read port.
// Depends on cfpp_pkg for the buffer depth.
`default_nettype none

module cfpp_frame_ram (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [cfpp_pkg::BufAddrW-1:0] waddr_i,
  input  wire logic [7:0]                   wdata_i,
  input  wire logic                         re_i,
  input  wire logic [cfpp_pkg::BufAddrW-1:0] raddr_i,
  output logic      [7:0]                   rdata_o
);
  import cfpp_pkg::*;

  logic [7:0] mem [BufDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/cfpp_out_reg.sv
// Output register stage: holds one result transaction until the consumer
// takes it. Depends on cfpp_pkg for the result type.
`default_nettype none

module cfpp_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire cfpp_pkg::result_t res_i,
  output logic                   free_o,
  output logic                   valid_o,
  input  wire logic              stall_i,
  output cfpp_pkg::result_t      res_o
);
  import cfpp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // The slot can be refilled in the same cycle its transaction completes.
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
